/* hdl/bcu_pkg.sv */
// Shared constants and controller/datapath interface types for the binomial coefficient unit.
`default_nettype none

package bcu_pkg;

   localparam int ARG_WIDTH    = 12;
   localparam int RESULT_WIDTH = 64;

   typedef struct packed {
      logic load;
      logic setup;
      logic mul_start;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic next_iter;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic loop_done;
   } status_type;

endpackage

`default_nettype wire

/* hdl/bcu_datapath.sv */
// Datapath: operand registers, shift-add multiplier, restoring divider and result register.
`default_nettype none

module bcu_datapath #(
   parameter int ARG_WIDTH    = bcu_pkg::ARG_WIDTH,
   parameter int RESULT_WIDTH = bcu_pkg::RESULT_WIDTH
) (
   input  wire                     clock,
   input  wire  [ARG_WIDTH-1:0]    set_size,
   input  wire  [ARG_WIDTH-1:0]    choose_count,
   input  bcu_pkg::cmd_type        cmd,
   output bcu_pkg::status_type     status,
   output logic [RESULT_WIDTH-1:0] coefficient,
   output logic                    wrapped
);

   localparam int ProdW = RESULT_WIDTH + ARG_WIDTH;

   logic [ARG_WIDTH-1:0]    n_ff, n_in;
   logic [ARG_WIDTH-1:0]    k_ff, k_in;
   logic [ARG_WIDTH-1:0]    i_ff, i_in;
   logic [ARG_WIDTH-1:0]    mult_ff, mult_in;
   logic [ARG_WIDTH-1:0]    rem_ff, rem_in;
   logic [RESULT_WIDTH-1:0] acc_ff, acc_in;
   logic [RESULT_WIDTH-1:0] quot_ff, quot_in;
   logic [ProdW-1:0]        prod_ff, prod_in;
   logic                    wrap_ff, wrap_in;
   logic [RESULT_WIDTH-1:0] coef_ff, coef_in;
   logic                    wflag_ff, wflag_in;

   logic [ARG_WIDTH-1:0]    diff;
   logic [ARG_WIDTH:0]      trial;
   logic [ARG_WIDTH:0]      trial_sub;

   assign diff      = n_ff - k_ff;
   assign trial     = {rem_ff, quot_ff[RESULT_WIDTH-1]};
   assign trial_sub = trial - {1'b0, i_ff};

   assign status.loop_done = i_ff > k_ff;
   assign coefficient      = coef_ff;
   assign wrapped          = wflag_ff;

   always_comb begin
      n_in     = n_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      mult_in  = mult_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      quot_in  = quot_ff;
      prod_in  = prod_ff;
      wrap_in  = wrap_ff;
      coef_in  = coef_ff;
      wflag_in = wflag_ff;

      if (cmd.load) begin
         n_in = set_size;
         k_in = choose_count;
      end
      if (cmd.setup) begin
         i_in    = ARG_WIDTH'(1);
         wrap_in = 1'b0;
         if (k_ff > n_ff) begin
            acc_in = '0;
            k_in   = '0;
         end else begin
            acc_in = RESULT_WIDTH'(1);
            k_in   = (k_ff > diff) ? diff : k_ff;
         end
      end
      if (cmd.mul_start) begin
         prod_in = '0;
         mult_in = n_ff - i_ff + ARG_WIDTH'(1);
      end
      if (cmd.mul_step) begin
         prod_in = {prod_ff[ProdW-2:0], 1'b0}
                 + (mult_ff[ARG_WIDTH-1] ? {{ARG_WIDTH{1'b0}}, acc_ff} : '0);
         mult_in = {mult_ff[ARG_WIDTH-2:0], 1'b0};
      end
      if (cmd.div_start) begin
         wrap_in = wrap_ff | (|prod_ff[ProdW-1:RESULT_WIDTH]);
         quot_in = prod_ff[RESULT_WIDTH-1:0];
         rem_in  = '0;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, i_ff}) begin
            rem_in  = trial_sub[ARG_WIDTH-1:0];
            quot_in = {quot_ff[RESULT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial[ARG_WIDTH-1:0];
            quot_in = {quot_ff[RESULT_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.next_iter) begin
         acc_in = quot_ff;
         i_in   = i_ff + ARG_WIDTH'(1);
      end
      if (cmd.out_load) begin
         coef_in  = acc_ff;
         wflag_in = wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      k_ff     <= k_in;
      i_ff     <= i_in;
      mult_ff  <= mult_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      quot_ff  <= quot_in;
      prod_ff  <= prod_in;
      wrap_ff  <= wrap_in;
      coef_ff  <= coef_in;
      wflag_ff <= wflag_in;
   end

endmodule

`default_nettype wire

/* hdl/bcu_ctrl.sv */
// Controller: sequences setup, multiply, divide and result handoff for each transaction.
`default_nettype none

module bcu_ctrl #(
   parameter int ARG_WIDTH    = bcu_pkg::ARG_WIDTH,
   parameter int RESULT_WIDTH = bcu_pkg::RESULT_WIDTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  bcu_pkg::status_type status,
   output bcu_pkg::cmd_type    cmd
);

   localparam int CntW = $clog2(RESULT_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_MUL,
      ST_DIV_START,
      ST_DIV,
      ST_NEXT,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.loop_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cnt_in        = CntW'(ARG_WIDTH - 1);
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIV_START;
            end else begin
               cnt_in = cnt_ff - CntW'(1);
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            cnt_in        = CntW'(RESULT_WIDTH - 1);
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff - CntW'(1);
            end
         end
         ST_NEXT: begin
            cmd.next_iter = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/binomial_coefficient_unit_top.sv */
// Top level of the binomial coefficient unit: C(n,k) by iterated multiply and exact divide.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: set_size, choose_count
//   rsp      out        rsp_tvalid/rsp_tready  tdata: coefficient; tuser: wrapped
//
// One transaction at a time. With k' = min(k, n-k), a transaction runs k'
// iterations (none for k > n); each iteration is a bit-serial shift-add
// multiply and a bit-serial restoring divide, and the operands are registered.
// Reset is synchronous and clears the sequencer and the result valid flag.
// A finished result waits in the output register; the next request is taken
// once the result has been moved there, and a stalled rsp holds only that move.
`default_nettype none

module binomial_coefficient_unit_top #(
   parameter int ARG_WIDTH    = bcu_pkg::ARG_WIDTH,
   parameter int RESULT_WIDTH = bcu_pkg::RESULT_WIDTH,
   localparam int ReqW = ((2 * ARG_WIDTH + 7) / 8) * 8,
   localparam int RspW = ((RESULT_WIDTH + 7) / 8) * 8
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_tvalid,
   output logic            req_tready,
   input  wire  [ReqW-1:0] req_tdata,   // set_size, choose_count, zero pad
   output logic            rsp_tvalid,
   input  wire             rsp_tready,
   output logic [RspW-1:0] rsp_tdata,   // coefficient, zero pad
   output logic            rsp_tuser    // wrapped
);

   bcu_pkg::cmd_type        cmd;
   bcu_pkg::status_type     status;
   logic [RESULT_WIDTH-1:0] coefficient;

   bcu_ctrl #(
      .ARG_WIDTH   (ARG_WIDTH),
      .RESULT_WIDTH(RESULT_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bcu_datapath #(
      .ARG_WIDTH   (ARG_WIDTH),
      .RESULT_WIDTH(RESULT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .set_size    (req_tdata[ARG_WIDTH-1:0]),
      .choose_count(req_tdata[2*ARG_WIDTH-1:ARG_WIDTH]),
      .cmd         (cmd),
      .status      (status),
      .coefficient (coefficient),
      .wrapped     (rsp_tuser)
   );

   assign rsp_tdata = RspW'(coefficient);

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised without a transaction in progress");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while holding a response");
`endif

endmodule

`default_nettype wire
